@@ rtl/gpio_bc_pkg.sv @@
// Shared types and constants for the GPIO bank controller.
// Holds the request layout, action codes and register map offsets.
// No dependencies.
package gpio_bc_pkg;

	// Action codes carried on the slave tuser.
	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_PIN   = 2'd2;

	// Register map region bounds (byte offsets).
	localparam logic [11:0] HW_LAST    = 12'h01C;
	localparam logic [11:0] DATA_FIRST = 12'h040;
	localparam logic [11:0] DATA_LAST  = 12'h04C;
	localparam logic [11:0] INL_FIRST  = 12'h060;
	localparam logic [11:0] INL_LAST   = 12'h06C;
	localparam logic [11:0] REG_BASE   = 12'h200;
	localparam logic [11:0] REG_FIRST  = 12'h204;
	localparam logic [11:0] REG_LAST   = 12'h2E4;

	// Offsets within one bank's 64-byte register window.
	localparam logic [5:0] SUB_DIR    = 6'h04;
	localparam logic [5:0] SUB_OE     = 6'h08;
	localparam logic [5:0] SUB_MASK   = 6'h0C;
	localparam logic [5:0] SUB_EN     = 6'h10;
	localparam logic [5:0] SUB_DIS    = 6'h14;
	localparam logic [5:0] SUB_STATUS = 6'h18;
	localparam logic [5:0] SUB_TYPE   = 6'h1C;
	localparam logic [5:0] SUB_POL    = 6'h20;
	localparam logic [5:0] SUB_ANY    = 6'h24;

	// Request payload, first member in the highest bits.
	typedef struct packed {
		logic        pin_level;
		logic [4:0]  pin_index;
		logic [1:0]  pin_bank;
		logic [31:0] write_data;
		logic [11:0] address;
	} req_t;

endpackage

@@ rtl/gpio_bank_controller_with_irq.sv @@
// GPIO bank controller top level: register file, interrupt logic and stream ports.
// Depends on gpio_bc_pkg for the request layout, action codes and register offsets.
//
// Each request (register read, register write or input pin change) enters an input
// register, is decoded and applied to the bank registers, and its result lands in an
// output register; the block takes one request per clock while the output register is
// free, and a result is held in the output register until the output side is ready.
// The decode and bitwise update lie between the input register and the output register.
// The result carries the read value, the bad offset flag, the combined interrupt and
// the driven pin levels of all banks after the request.
module gpio_bank_controller_with_irq
	import gpio_bc_pkg::*;
#(
	parameter int NUM_BANKS     = 4,
	parameter int PINS_PER_BANK = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [11:0] address, [43:12] write_data, [45:44] pin_bank, [50:46] pin_index,
	// [51] pin_level, [55:52] zero
	input  logic [55:0]  s_axis_tdata,
	// [1:0] action
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] read_data, [32] irq_out, [64:33] pins_bank0, [96:65] pins_bank1,
	// [128:97] pins_bank2, [160:129] pins_bank3, [167:161] zero
	output logic [167:0] m_axis_tdata,
	// [0] bad_offset
	output logic [0:0]   m_axis_tuser
);

	localparam int PW = PINS_PER_BANK;

	// Input stage.
	logic        valid_s1;
	req_t        req_s1;
	logic [1:0]  act_s1;

	// Output stage.
	logic        valid_s2;
	logic [31:0] rd_s2;
	logic        bad_s2;
	logic        irq_s2;
	logic [3:0][31:0] pins_s2;

	// Bank state.
	logic [NUM_BANKS-1:0][31:0] hws_q, hws_n;
	logic [NUM_BANKS-1:0][PW-1:0] od_q, od_n;
	logic [NUM_BANKS-1:0][PW-1:0] dir_q, dir_n;
	logic [NUM_BANKS-1:0][PW-1:0] oe_q, oe_n;
	logic [NUM_BANKS-1:0][PW-1:0] mask_q, mask_n;
	logic [NUM_BANKS-1:0][PW-1:0] stat_q, stat_n;
	logic [NUM_BANKS-1:0][PW-1:0] type_q, type_n;
	logic [NUM_BANKS-1:0][PW-1:0] pol_q, pol_n;
	logic [NUM_BANKS-1:0][PW-1:0] any_q, any_n;
	logic [NUM_BANKS-1:0][PW-1:0] lvl_q, lvl_n;

	logic        out_free;
	logic        fire;

	// Decode signals.
	logic [11:0] addr;
	logic [11:0] roff;
	logic [5:0]  reg_sub;
	logic        hw_hit, dat_hit, inl_hit, reg_hit;
	logic [1:0]  acc_bank;
	logic        bank_ok, sub_known, is_rd, is_wr, is_acc;
	logic        acc_ok, bad_c, level_all, pin_ok;
	logic [PW-1:0] wd_p, pbit;
	logic [31:0] rd_c;
	logic        irq_c;
	logic [3:0][31:0] pins_c;

	// Handshake: the input register advances when it is empty or the output register is free.
	assign out_free      = !valid_s2 || m_axis_tready;
	assign fire          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1 <= req_t'(s_axis_tdata[51:0]);
			act_s1 <= s_axis_tuser;
		end
	end

	// Address decode into region, bank and register within the bank.
	always_comb begin
		addr      = req_s1.address;
		roff      = addr - REG_BASE;
		reg_sub   = roff[5:0];
		hw_hit    = (addr <= HW_LAST);
		dat_hit   = (addr >= DATA_FIRST) && (addr <= DATA_LAST);
		inl_hit   = (addr >= INL_FIRST) && (addr <= INL_LAST);
		reg_hit   = (addr >= REG_FIRST) && (addr <= REG_LAST);
		if (hw_hit) begin
			acc_bank = addr[4:3];
		end else if (reg_hit) begin
			acc_bank = roff[7:6];
		end else begin
			acc_bank = addr[3:2];
		end
		bank_ok = ({30'd0, acc_bank} < 32'(NUM_BANKS));
		case (reg_sub)
			SUB_DIR, SUB_OE, SUB_MASK, SUB_EN, SUB_DIS,
			SUB_STATUS, SUB_TYPE, SUB_POL, SUB_ANY: sub_known = 1'b1;
			default: sub_known = 1'b0;
		endcase
		is_rd  = (act_s1 == ACT_READ);
		is_wr  = (act_s1 == ACT_WRITE);
		is_acc = is_rd || is_wr;
		acc_ok = is_acc && (hw_hit || dat_hit || inl_hit || reg_hit) && bank_ok
			&& !(reg_hit && !sub_known);
		bad_c  = is_acc && !acc_ok;
		// Any write to a bank register other than the mask re-evaluates level pins.
		level_all = is_wr && acc_ok && reg_hit && (reg_sub != SUB_MASK);
		pin_ok = (act_s1 == ACT_PIN)
			&& ({30'd0, req_s1.pin_bank} < 32'(NUM_BANKS))
			&& ({27'd0, req_s1.pin_index} < 32'(PINS_PER_BANK));
		wd_p = req_s1.write_data[PW-1:0];
		pbit = PW'(1) << req_s1.pin_index;
	end

	// Register read mux.
	always_comb begin
		rd_c = 32'd0;
		for (int k = 0; k < NUM_BANKS; k++) begin
			if (is_rd && acc_ok && (acc_bank == 2'(k))) begin
				if (hw_hit) begin
					rd_c = addr[2] ? {16'd0, hws_q[k][31:16]} : {16'd0, hws_q[k][15:0]};
				end else if (dat_hit) begin
					rd_c = 32'(od_q[k]);
				end else if (inl_hit) begin
					rd_c = 32'(lvl_q[k]);
				end else begin
					case (reg_sub)
						SUB_DIR:    rd_c = 32'(dir_q[k]);
						SUB_OE:     rd_c = 32'(oe_q[k]);
						SUB_MASK:   rd_c = 32'(mask_q[k]);
						SUB_STATUS: rd_c = 32'(stat_q[k]);
						SUB_TYPE:   rd_c = 32'(type_q[k]);
						SUB_POL:    rd_c = 32'(pol_q[k]);
						SUB_ANY:    rd_c = 32'(any_q[k]);
						default:    rd_c = 32'd0;
					endcase
				end
			end
		end
	end

	// Next bank state for the request in the input register.
	always_comb begin
		logic [31:0] merged;
		logic [31:0] od_ext;
		logic [31:0] od_merged;
		logic [PW-1:0] old_lvl;
		hws_n  = hws_q;
		od_n   = od_q;
		dir_n  = dir_q;
		oe_n   = oe_q;
		mask_n = mask_q;
		stat_n = stat_q;
		type_n = type_q;
		pol_n  = pol_q;
		any_n  = any_q;
		lvl_n  = lvl_q;
		for (int k = 0; k < NUM_BANKS; k++) begin
			merged    = addr[2] ? {req_s1.write_data[15:0], hws_q[k][15:0]}
				: {hws_q[k][31:16], req_s1.write_data[15:0]};
			od_ext    = 32'(od_q[k]);
			od_merged = addr[2] ? {req_s1.write_data[15:0], od_ext[15:0]}
				: {od_ext[31:16], req_s1.write_data[15:0]};
			old_lvl   = lvl_q[k];
			if (fire && is_wr && acc_ok && (acc_bank == 2'(k))) begin
				if (hw_hit) begin
					hws_n[k] = merged;
					od_n[k]  = PW'(od_merged);
				end else if (dat_hit) begin
					od_n[k] = wd_p;
				end else if (reg_hit) begin
					case (reg_sub)
						SUB_DIR:    dir_n[k]  = wd_p;
						SUB_OE:     oe_n[k]   = wd_p;
						SUB_EN:     mask_n[k] = mask_q[k] & ~wd_p;
						SUB_DIS:    mask_n[k] = mask_q[k] | wd_p;
						SUB_STATUS: stat_n[k] = stat_q[k] & ~wd_p;
						SUB_TYPE:   type_n[k] = wd_p;
						SUB_POL:    pol_n[k]  = wd_p;
						SUB_ANY:    any_n[k]  = wd_p;
						default:    mask_n[k] = mask_q[k];
					endcase
				end
			end
			// Input pin change: edge detection on the changed pin.
			if (fire && pin_ok && (req_s1.pin_bank == 2'(k))) begin
				lvl_n[k] = req_s1.pin_level ? (old_lvl | pbit) : (old_lvl & ~pbit);
				if (((old_lvl ^ lvl_n[k]) & type_q[k] & pbit) != '0) begin
					if ((any_q[k] & pbit) != '0) begin
						stat_n[k] = stat_n[k] | pbit;
					end else begin
						stat_n[k] = stat_n[k] | (~(lvl_n[k] ^ pol_q[k]) & pbit);
					end
				end
			end
			// Level-type pins set status while the level matches the polarity.
			if ((fire && level_all) || (fire && pin_ok && (req_s1.pin_bank == 2'(k)))) begin
				stat_n[k] = stat_n[k] | (~(lvl_n[k] ^ pol_n[k]) & ~type_n[k]);
			end
		end
	end

	// Combined interrupt and driven pins after the update.
	always_comb begin
		irq_c  = 1'b0;
		pins_c = '0;
		for (int k = 0; k < NUM_BANKS; k++) begin
			irq_c     = irq_c | ((stat_n[k] & ~mask_n[k]) != '0);
			pins_c[k] = 32'((od_n[k] & dir_n[k]) | ~dir_n[k]);
		end
	end

	// Bank state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hws_q  <= '0;
			od_q   <= '0;
			dir_q  <= '0;
			oe_q   <= '0;
			mask_q <= '0;
			stat_q <= '0;
			type_q <= '1;
			pol_q  <= '0;
			any_q  <= '0;
			lvl_q  <= '0;
		end else begin
			hws_q  <= hws_n;
			od_q   <= od_n;
			dir_q  <= dir_n;
			oe_q   <= oe_n;
			mask_q <= mask_n;
			stat_q <= stat_n;
			type_q <= type_n;
			pol_q  <= pol_n;
			any_q  <= any_n;
			lvl_q  <= lvl_n;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rd_s2   <= rd_c;
			bad_s2  <= bad_c;
			irq_s2  <= irq_c;
			pins_s2 <= pins_c;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0, pins_s2[3], pins_s2[2], pins_s2[1], pins_s2[0],
		irq_s2, rd_s2};
	assign m_axis_tuser  = bad_s2;

	// A flagged access never returns data.
	a_bad_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && bad_s2 |-> rd_s2 == 32'd0)
		else $error("bad offset result carries nonzero read data");

	// A request held in the input register stays put until it is processed.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(req_s1) && $stable(act_s1))
		else $error("input register changed while stalled");

	// Status bits are sticky: only a register write can clear them.
	a_status_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && is_wr) |=> (stat_q & $past(stat_q)) == $past(stat_q))
		else $error("status bit cleared without a write");

	// The interrupt mask changes only through a processed register write.
	a_mask_write_only: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && is_wr) |=> $stable(mask_q))
		else $error("interrupt mask changed without a write");

	// Reads leave the output configuration untouched.
	a_read_no_side_effect: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_rd |=> $stable(od_q) && $stable(dir_q) && $stable(hws_q))
		else $error("register read changed output state");

endmodule
